@@ rtl/des_pkg.sv @@
// Shared constants, codes and types for the dynamic adjacency edge store.
package des_pkg;

  localparam int MAX_NODES  = 64;
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int DEG_W      = NODE_W + 1;
  localparam int KEY_W      = 2 * NODE_W;
  localparam int KEY_DEPTH  = MAX_NODES * MAX_NODES;
  localparam int EDGE_W     = 13;
  localparam int IN_TDATA_W = 24;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TEST   = 2'd2,
    OP_READ   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOCHANGE = 2'd1,
    ST_RANGE    = 2'd2
  } status_t;

  typedef struct packed {
    opcode_t             op;
    logic [NODE_W-1:0]   src;
    logic [NODE_W-1:0]   tgt;
    logic [NODE_W-1:0]   slot;
  } cmd_t;

  // slot map entry: presence flag and slot in the source's list
  typedef struct packed {
    logic                valid;
    logic [NODE_W-1:0]   pos;
  } map_ent_t;

  typedef struct packed {
    logic                we;
    logic [KEY_W-1:0]    waddr;
    logic [NODE_W-1:0]   wdata;
    logic [KEY_W-1:0]    raddr;
  } list_req_t;

  typedef struct packed {
    logic                we;
    logic [KEY_W-1:0]    waddr;
    map_ent_t            wdata;
    logic [KEY_W-1:0]    raddr;
  } map_req_t;

  typedef struct packed {
    logic                we;
    logic [NODE_W-1:0]   waddr;
    logic [DEG_W-1:0]    wdata;
    logic [NODE_W-1:0]   raddr;
  } deg_req_t;

  // result fields, status in the lowest bits
  typedef struct packed {
    logic [DEG_W-1:0]    busiest_degree;
    logic [NODE_W-1:0]   busiest_node;
    logic [EDGE_W-1:0]   total_edges;
    logic [DEG_W-1:0]    source_degree;
    logic [NODE_W-1:0]   neighbour_read;
    status_t             status;
  } res_t;

endpackage

@@ rtl/des_ram.sv @@
// Generic simple dual-port RAM with registered read.
module des_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/des_ctrl.sv @@
// Operation sequencer: clearing pass, map/list/degree read-modify-write, max-degree rescan.
module des_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [des_pkg::DEG_W-1:0]   nodes_in_use,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  des_pkg::cmd_t               cmd,
  output des_pkg::list_req_t          list_req,
  input  logic [des_pkg::NODE_W-1:0]  list_rdata,
  output des_pkg::map_req_t           map_req,
  input  des_pkg::map_ent_t           map_rdata,
  output des_pkg::deg_req_t           deg_req,
  input  logic [des_pkg::DEG_W-1:0]   deg_rdata,
  output logic                        res_valid,
  input  logic                        res_ready,
  output des_pkg::res_t               res
);
  import des_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_RD1   = 7'b0000100,
    S_RD2   = 7'b0001000,
    S_RM2   = 7'b0010000,
    S_SCAN  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t             state;
  cmd_t               cmd_q;
  logic [KEY_W-1:0]   clr_idx;
  logic [DEG_W-1:0]   deg_q;
  logic [NODE_W-1:0]  pos_q;
  logic [EDGE_W-1:0]  edges;
  logic [NODE_W-1:0]  holder;
  logic [DEG_W-1:0]   holder_deg;
  logic [DEG_W-1:0]   scan_idx;
  logic               cmp_valid;
  logic [NODE_W-1:0]  cmp_idx;
  status_t            status_q;
  logic [NODE_W-1:0]  nread_q;
  logic [DEG_W-1:0]   sdeg_q;

  logic               src_ok;
  logic               tgt_ok;
  logic               slot_ok;
  logic               deg_full;
  logic [DEG_W-1:0]   deg_inc;
  logic [DEG_W-1:0]   deg_dec;
  logic [DEG_W-1:0]   lim;
  logic [KEY_W-1:0]   key;
  logic               scan_hit;
  logic               scan_end;

  assign src_ok   = {1'b0, cmd_q.src} < nodes_in_use;
  assign tgt_ok   = {1'b0, cmd_q.tgt} < nodes_in_use;
  assign slot_ok  = {1'b0, cmd_q.slot} < deg_rdata;
  assign deg_full = deg_rdata >= DEG_W'(MAX_NODES);
  assign deg_inc  = deg_rdata + DEG_W'(1);
  assign deg_dec  = (deg_rdata != '0) ? deg_rdata - DEG_W'(1) : '0;
  assign lim      = (nodes_in_use > DEG_W'(MAX_NODES)) ? DEG_W'(MAX_NODES) : nodes_in_use;
  assign key      = {cmd_q.src, cmd_q.tgt};
  // the source's own entry is skipped, as it never beats its own degree
  assign scan_hit = cmp_valid && (cmp_idx != cmd_q.src) && (deg_rdata > deg_q);
  assign scan_end = !cmp_valid && (scan_idx >= lim);

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res = '{busiest_degree: holder_deg, busiest_node: holder, total_edges: edges,
                 source_degree: sdeg_q, neighbour_read: nread_q, status: status_q};

  always_comb begin
    list_req       = '0;
    list_req.raddr = {cmd_q.src, cmd_q.slot};
    map_req        = '0;
    map_req.raddr  = key;
    deg_req        = '0;
    deg_req.raddr  = cmd_q.src;
    unique case (state)
      S_CLEAR: begin
        map_req.we    = 1'b1;
        map_req.waddr = clr_idx;
        deg_req.we    = 1'b1;
        deg_req.waddr = clr_idx[NODE_W-1:0];
      end
      S_IDLE: begin
        map_req.raddr = {cmd.src, cmd.tgt};
        deg_req.raddr = cmd.src;
      end
      S_RD1: begin
        if (src_ok && tgt_ok && cmd_q.op == OP_INSERT && !map_rdata.valid && !deg_full) begin
          list_req.we    = 1'b1;
          list_req.waddr = {cmd_q.src, deg_rdata[NODE_W-1:0]};
          list_req.wdata = cmd_q.tgt;
          map_req.we     = 1'b1;
          map_req.waddr  = key;
          map_req.wdata  = '{valid: 1'b1, pos: deg_rdata[NODE_W-1:0]};
          deg_req.we     = 1'b1;
          deg_req.waddr  = cmd_q.src;
          deg_req.wdata  = deg_inc;
        end else if (src_ok && tgt_ok && cmd_q.op == OP_REMOVE && map_rdata.valid) begin
          list_req.raddr = {cmd_q.src, deg_dec[NODE_W-1:0]};
          map_req.we     = 1'b1;
          map_req.waddr  = key;
          deg_req.we     = 1'b1;
          deg_req.waddr  = cmd_q.src;
          deg_req.wdata  = deg_dec;
        end
      end
      S_RM2: begin
        // last neighbour fills the freed slot; if it is the removed edge it stays absent
        list_req.we    = 1'b1;
        list_req.waddr = {cmd_q.src, pos_q};
        list_req.wdata = list_rdata;
        map_req.we     = 1'b1;
        map_req.waddr  = {cmd_q.src, list_rdata};
        map_req.wdata  = '{valid: (list_rdata != cmd_q.tgt), pos: pos_q};
      end
      S_SCAN: begin
        deg_req.raddr = scan_idx[NODE_W-1:0];
      end
      S_RD2, S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      edges      <= '0;
      holder     <= '0;
      holder_deg <= '0;
      cmp_valid  <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + KEY_W'(1);
          if (&clr_idx) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd_q <= cmd;
            state <= S_RD1;
          end
        end
        S_RD1: begin
          sdeg_q   <= deg_rdata;
          nread_q  <= '0;
          status_q <= ST_OK;
          state    <= S_DONE;
          priority if (!src_ok) begin
            status_q <= ST_RANGE;
            sdeg_q   <= '0;
          end else if (cmd_q.op == OP_READ) begin
            if (slot_ok) begin
              state <= S_RD2;
            end else begin
              status_q <= ST_RANGE;
            end
          end else if (!tgt_ok) begin
            status_q <= ST_RANGE;
          end else begin
            unique case (cmd_q.op)
              OP_INSERT: begin
                if (map_rdata.valid || deg_full) begin
                  status_q <= ST_NOCHANGE;
                end else begin
                  sdeg_q <= deg_inc;
                  edges  <= edges + EDGE_W'(1);
                  if (cmd_q.src == holder || deg_inc > holder_deg) begin
                    holder     <= cmd_q.src;
                    holder_deg <= deg_inc;
                  end
                end
              end
              OP_REMOVE: begin
                if (!map_rdata.valid) begin
                  status_q <= ST_NOCHANGE;
                end else begin
                  pos_q  <= map_rdata.pos;
                  deg_q  <= deg_dec;
                  sdeg_q <= deg_dec;
                  edges  <= edges - EDGE_W'(1);
                  state  <= S_RM2;
                end
              end
              OP_TEST: begin
                status_q <= map_rdata.valid ? ST_OK : ST_NOCHANGE;
              end
              OP_READ: ;
            endcase
          end
        end
        S_RD2: begin
          nread_q <= list_rdata;
          state   <= S_DONE;
        end
        S_RM2: begin
          if (cmd_q.src == holder) begin
            scan_idx  <= '0;
            cmp_valid <= 1'b0;
            state     <= S_SCAN;
          end else begin
            state <= S_DONE;
          end
        end
        S_SCAN: begin
          // one degree read issued per cycle, compared the cycle after
          cmp_valid <= scan_idx < lim;
          cmp_idx   <= scan_idx[NODE_W-1:0];
          if (scan_idx < lim) begin
            scan_idx <= scan_idx + DEG_W'(1);
          end
          priority if (scan_hit) begin
            holder     <= cmp_idx;
            holder_deg <= deg_rdata;
            cmp_valid  <= 1'b0;
            state      <= S_DONE;
          end else if (scan_end) begin
            holder_deg <= deg_q;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

endmodule

@@ rtl/dynamic_adjacency_edge_store_core.sv @@
// Sequence: insert, test and rejected ops pass S_RD1 then S_DONE after input transfer,
// read adds S_RD2 and plain remove S_RM2; remove on the busiest node adds a degree scan
// over up to min(nodes_in_use, 64) nodes, one degree memory read per cycle.
// The sequencer handles one item at a time, the output register frees it early.
// Reset: rst clears control state, then a clearing pass empties the 4096-entry slot map
// and the degree memories with s_tready low; cfg writes are taken during it.
module dynamic_adjacency_edge_store_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [des_pkg::DEG_W-1:0]        cfg_wdata,   // nodes_in_use
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [des_pkg::IN_TDATA_W-1:0]   s_tdata,     // source_node, target_node, slot_index
  input  logic [1:0]                       s_tuser,     // opcode
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // status, neighbour_read, source_degree, total_edges, busiest_node, busiest_degree
  output logic [des_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import des_pkg::*;

  localparam int PAD_W = OUT_TDATA_W - $bits(res_t);

  logic [DEG_W-1:0]  nodes_in_use;
  cmd_t              cmd;
  list_req_t         list_req;
  map_req_t          map_req;
  deg_req_t          deg_req;
  logic [NODE_W-1:0] list_rdata;
  map_ent_t          map_rdata;
  logic [DEG_W-1:0]  deg_rdata;
  logic              res_valid;
  logic              res_ready;
  res_t              res;
  res_t              out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      nodes_in_use <= '0;
    end else if (cfg_we) begin
      nodes_in_use <= cfg_wdata;
    end
  end

  assign cmd = '{op: opcode_t'(s_tuser),
                 src: s_tdata[NODE_W-1:0],
                 tgt: s_tdata[2*NODE_W-1:NODE_W],
                 slot: s_tdata[3*NODE_W-1:2*NODE_W]};

  des_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .nodes_in_use (nodes_in_use),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .cmd          (cmd),
    .list_req     (list_req),
    .list_rdata   (list_rdata),
    .map_req      (map_req),
    .map_rdata    (map_rdata),
    .deg_req      (deg_req),
    .deg_rdata    (deg_rdata),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  des_ram #(.WIDTH(NODE_W), .DEPTH(KEY_DEPTH)) u_list_ram (
    .clk   (clk),
    .we    (list_req.we),
    .waddr (list_req.waddr),
    .wdata (list_req.wdata),
    .raddr (list_req.raddr),
    .rdata (list_rdata)
  );

  des_ram #(.WIDTH($bits(map_ent_t)), .DEPTH(KEY_DEPTH)) u_map_ram (
    .clk   (clk),
    .we    (map_req.we),
    .waddr (map_req.waddr),
    .wdata (map_req.wdata),
    .raddr (map_req.raddr),
    .rdata (map_rdata)
  );

  des_ram #(.WIDTH(DEG_W), .DEPTH(MAX_NODES)) u_deg_ram (
    .clk   (clk),
    .we    (deg_req.we),
    .waddr (deg_req.waddr),
    .wdata (deg_req.wdata),
    .raddr (deg_req.raddr),
    .rdata (deg_rdata)
  );

  // output register: the sequencer hands off and moves on while the result waits
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, out_res};

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("pending result changed before handoff");

  a_handoff: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready |=> m_tvalid)
    else $error("handed-off result not presented");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !map_req.we && !list_req.we && !deg_req.we)
    else $error("memory write while waiting for input");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.status == ST_OK || res.status == ST_NOCHANGE || res.status == ST_RANGE)
    else $error("undefined status code");

endmodule

@@ verif/tb_dynamic_adjacency_edge_store_core.sv @@
// Testbench for the dynamic adjacency edge store: random and directed ops against a graph model.
module tb_dynamic_adjacency_edge_store_core;
  import des_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [DEG_W-1:0] cfg_wdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;  // source_node, target_node, slot_index
  logic [1:0] s_tuser = '0;             // opcode
  logic m_tvalid;
  logic m_tready = 1'b0;
  // status, neighbour_read, source_degree, total_edges, busiest_node, busiest_degree
  logic [OUT_TDATA_W-1:0] m_tdata;

  dynamic_adjacency_edge_store_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // graph model
  bit [NODE_W-1:0] adj_list [KEY_DEPTH];
  bit              key_present [KEY_DEPTH];
  bit [NODE_W-1:0] key_slot [KEY_DEPTH];
  bit [DEG_W-1:0]  out_degree [MAX_NODES];
  bit [EDGE_W-1:0] model_edges;
  bit [NODE_W-1:0] busiest;
  bit [DEG_W-1:0]  live_nodes;

  // queues fill at the front and drain from the back
  cmd_t edge_cmd_q[$];
  res_t expected_results[$];
  int   mismatch_cnt = 0;
  logic long_hold_req = 1'b0;

  function automatic bit node_valid(input logic [NODE_W-1:0] id);
    return id < live_nodes;
  endfunction

  task automatic apply_graph_op(input cmd_t c, output res_t r);
    logic [KEY_W-1:0]  key;
    logic [NODE_W-1:0] pos;
    logic [NODE_W-1:0] lastpos;
    logic [NODE_W-1:0] moved;
    logic [DEG_W-1:0]  d;
    int                lim;
    r = '0;
    r.status = ST_OK;
    key = {c.src, c.tgt};
    if (!node_valid(c.src)) begin
      r.status = ST_RANGE;
    end else if (c.op == OP_READ) begin
      if (c.slot < out_degree[c.src]) r.neighbour_read = adj_list[{c.src, c.slot}];
      else r.status = ST_RANGE;
    end else if (!node_valid(c.tgt)) begin
      r.status = ST_RANGE;
    end else begin
      case (c.op)
        OP_INSERT: begin
          d = out_degree[c.src];
          if (key_present[key] || d >= MAX_NODES) begin
            r.status = ST_NOCHANGE;
          end else begin
            adj_list[{c.src, d[NODE_W-1:0]}] = c.tgt;
            key_slot[key] = d[NODE_W-1:0];
            key_present[key] = 1'b1;
            out_degree[c.src] = d + 1'b1;
            if (out_degree[c.src] > out_degree[busiest]) busiest = c.src;
            model_edges = model_edges + 1'b1;
          end
        end
        OP_REMOVE: begin
          if (!key_present[key]) begin
            r.status = ST_NOCHANGE;
          end else begin
            pos = key_slot[key];
            d = out_degree[c.src];
            lastpos = (d > 0) ? NODE_W'(d - 1'b1) : '0;
            moved = adj_list[{c.src, lastpos}];
            adj_list[{c.src, pos}] = moved;
            key_slot[{c.src, moved}] = pos;
            key_present[key] = 1'b0;
            out_degree[c.src] = (d > 0) ? d - 1'b1 : '0;
            if (c.src == busiest) begin
              lim = (live_nodes < MAX_NODES) ? live_nodes : MAX_NODES;
              for (int n = 0; n < lim; n++) begin
                if (out_degree[n] > out_degree[c.src]) begin
                  busiest = NODE_W'(n);
                  break;
                end
              end
            end
            model_edges = model_edges - 1'b1;
          end
        end
        default: r.status = key_present[key] ? ST_OK : ST_NOCHANGE;
      endcase
    end
    if (node_valid(c.src)) r.source_degree = out_degree[c.src];
    r.total_edges = model_edges;
    r.busiest_node = busiest;
    r.busiest_degree = out_degree[busiest];
  endtask

  // mostly zero, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // input driver
  cmd_t cur_cmd;
  res_t predicted;
  int   in_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        apply_graph_op(cur_cmd, predicted);
        expected_results.push_front(predicted);
      end
      if (in_gap > 0) begin
        in_gap--;
        s_tvalid <= 1'b0;
      end else if (edge_cmd_q.size() > 0) begin
        cur_cmd = edge_cmd_q.pop_back();
        s_tdata <= {6'b0, cur_cmd.slot, cur_cmd.tgt, cur_cmd.src};
        s_tuser <= cur_cmd.op;
        s_tvalid <= 1'b1;
        in_gap = pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // output ready, with one long hold-off on request
  int out_gap = 0;
  bit hold_taken = 1'b0;

  always @(posedge clk) begin
    if (long_hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      out_gap = 400;
    end
    if (out_gap > 0) begin
      out_gap--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      out_gap = pick_gap();
    end
  end

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  // result monitor
  res_t got;
  res_t want;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = res_t'(m_tdata[$bits(res_t)-1:0]);
      if (expected_results.size() == 0) begin
        $display("%0t: result transfer with nothing expected, actual %h", $time, m_tdata);
        mismatch_cnt++;
      end else begin
        want = expected_results.pop_back();
        check_field("status", want.status, got.status);
        check_field("neighbour_read", want.neighbour_read, got.neighbour_read);
        check_field("source_degree", want.source_degree, got.source_degree);
        check_field("total_edges", want.total_edges, got.total_edges);
        check_field("busiest_node", want.busiest_node, got.busiest_node);
        check_field("busiest_degree", want.busiest_degree, got.busiest_degree);
      end
    end
  end

  // stimulus helpers
  task automatic push_cmd(input opcode_t op, input int src, input int tgt, input int slot);
    cmd_t c;
    c.op = op;
    c.src = NODE_W'(src);
    c.tgt = NODE_W'(tgt);
    c.slot = NODE_W'(slot);
    while (edge_cmd_q.size() >= 2) @(posedge clk);
    edge_cmd_q.push_front(c);
  endtask

  task automatic wait_idle();
    while (edge_cmd_q.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_nodes(input int v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= DEG_W'(v);
    live_nodes = DEG_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // well-formed ops on the current graph, with some noise
  task automatic random_cmd();
    opcode_t op;
    int      src;
    int      tgt;
    int      slot;
    int      r;
    int      d;
    src = $urandom_range(63);
    tgt = $urandom_range(63);
    slot = $urandom_range(63);
    r = $urandom_range(99);
    op = (r < 35) ? OP_INSERT : (r < 60) ? OP_REMOVE : (r < 80) ? OP_TEST : OP_READ;
    if ($urandom_range(99) >= 10 && live_nodes > 0) begin
      if ($urandom_range(99) < 30)
        src = $urandom_range((live_nodes < 4) ? live_nodes - 1 : 3);
      else
        src = $urandom_range(live_nodes - 1);
      tgt = $urandom_range(live_nodes - 1);
      d = out_degree[src];
      if (d > 0 && $urandom_range(99) < 75) begin
        if (op == OP_REMOVE || op == OP_TEST) tgt = adj_list[{src[5:0], 6'($urandom_range(d - 1))}];
        if (op == OP_READ && $urandom_range(99) < 85) slot = $urandom_range(d - 1);
      end
    end
    push_cmd(op, src, tgt, slot);
  endtask

  initial begin
    int order[MAX_NODES];
    int j;
    int t;
    int hot;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // no valid nodes: everything is out of range
    write_nodes(0);
    push_cmd(OP_INSERT, 0, 0, 0);
    push_cmd(OP_READ, 0, 0, 0);
    push_cmd(OP_TEST, 0, 0, 0);
    push_cmd(OP_REMOVE, 0, 0, 0);
    wait_idle();

    write_nodes(64);
    push_cmd(OP_INSERT, 0, 63, 0);
    push_cmd(OP_INSERT, 0, 63, 0);    // duplicate
    push_cmd(OP_INSERT, 63, 0, 0);
    push_cmd(OP_INSERT, 63, 63, 0);   // self loop, 63 becomes busiest
    push_cmd(OP_TEST, 0, 63, 0);
    push_cmd(OP_TEST, 0, 1, 0);
    push_cmd(OP_READ, 63, 0, 1);
    push_cmd(OP_READ, 63, 0, 2);      // past degree
    push_cmd(OP_READ, 0, 0, 63);
    push_cmd(OP_REMOVE, 0, 5, 0);     // absent
    push_cmd(OP_INSERT, 0, 1, 0);
    push_cmd(OP_INSERT, 0, 2, 0);     // node 0 takes over as busiest
    push_cmd(OP_REMOVE, 0, 63, 0);    // busiest, scan keeps node 0
    push_cmd(OP_READ, 0, 0, 0);       // last entry moved into slot 0
    push_cmd(OP_REMOVE, 0, 2, 0);     // scan hands busiest to 63
    push_cmd(OP_REMOVE, 63, 63, 0);
    push_cmd(OP_INSERT, 5, 7, 0);
    wait_idle();

    write_nodes(58);
    push_cmd(OP_INSERT, 3, 60, 0);    // bad target
    push_cmd(OP_TEST, 60, 1, 0);      // bad source
    push_cmd(OP_REMOVE, 5, 63, 0);
    push_cmd(OP_READ, 5, 63, 0);      // target ignored by read
    wait_idle();

    write_nodes(64);
    for (int i = 0; i < 140; i++) begin
      if (i == 80) long_hold_req = 1'b1;
      if (i == 120) begin
        // fill one node to full degree in random order
        hot = $urandom_range(63);
        for (int k = 0; k < MAX_NODES; k++) order[k] = k;
        for (int k = MAX_NODES - 1; k > 0; k--) begin
          j = $urandom_range(k);
          t = order[k];
          order[k] = order[j];
          order[j] = t;
        end
        for (int k = 0; k < MAX_NODES; k++) push_cmd(OP_INSERT, hot, order[k], 0);
        push_cmd(OP_INSERT, hot, order[0], 0);
        push_cmd(OP_READ, hot, 0, 63);
      end
      random_cmd();
    end
    // sender waits for the block to drain
    wait_idle();
    for (int i = 0; i < 40; i++) random_cmd();
    wait_idle();

    // shrink: stored edges stay, busiest may drop out of range
    write_nodes(5);
    for (int i = 0; i < 150; i++) random_cmd();
    wait_idle();

    write_nodes(1);
    for (int i = 0; i < 30; i++) random_cmd();
    wait_idle();

    write_nodes(64);
    for (int i = 0; i < 150; i++) random_cmd();
    wait_idle();

    repeat (100) @(posedge clk);
    if (mismatch_cnt == 0 && expected_results.size() == 0) begin
      $display("dynamic_adjacency_edge_store_core test passed");
    end else begin
      $display("dynamic_adjacency_edge_store_core test failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("dynamic_adjacency_edge_store_core test failed");
    $finish;
  end

endmodule
